/* sv/bea_pkg.sv */
// ----------------------------------------------------------------------------
// bea_pkg
// Shared types and constants for the button edge detector with auto-repeat
// ----------------------------------------------------------------------------
package bea_pkg;

    // number of buttons that are really wired (1 .. 8)
    localparam int BUTTON_COUNT = 8;
    // width of the button byte and of every mask field
    localparam int BYTE_W       = 8;
    // repeat period / counter width
    localparam int PERIOD_W     = 8;
    // configuration register file
    localparam int REG_COUNT    = 8;
    localparam int REG_SEL_W    = $clog2(REG_COUNT);
    localparam int CFG_INDEX_W  = REG_SEL_W + 1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(4);
    localparam logic [BYTE_W-1:0]   BUTTON_MASK  = BYTE_W'((1 << BUTTON_COUNT) - 1);

    typedef logic [REG_COUNT-1:0][PERIOD_W-1:0]    period_array_t;
    typedef logic [BUTTON_COUNT-1:0][PERIOD_W-1:0] counter_array_t;

    typedef struct packed {
        logic              sample_valid;
        logic [BYTE_W-1:0] raw_buttons;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] held_mask;
        logic [BYTE_W-1:0] press_edges;
        logic [BYTE_W-1:0] release_edges;
        logic [BYTE_W-1:0] repeat_mask;
    } out_item_t;

    // state carried from one poll to the next
    typedef struct packed {
        logic [BYTE_W-1:0] held;
        counter_array_t    counter;
    } poll_state_t;

endpackage

/* sv/bea_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bea_cfg_regs
// Per-button repeat period registers, write-only
// ----------------------------------------------------------------------------
module bea_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [bea_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bea_pkg::PERIOD_W-1:0]     cfg_wdata,
    output bea_pkg::period_array_t           periods
);

    bea_pkg::period_array_t period_reg;
    bea_pkg::period_array_t period_next;

    always_comb begin
        period_next = period_reg;
        // writes beyond the register list are dropped
        if (cfg_wr_en && (cfg_index < bea_pkg::CFG_INDEX_W'(bea_pkg::REG_COUNT))) begin
            period_next[cfg_index[bea_pkg::REG_SEL_W-1:0]] = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bea_pkg::REG_COUNT; i++) begin
                period_reg[i] <= bea_pkg::PERIOD_RESET;
            end
        end else begin
            period_reg <= period_next;
        end
    end

    assign periods = period_reg;

endmodule

/* sv/bea_step.sv */
// ----------------------------------------------------------------------------
// bea_step
// One poll: edge detect and per-button repeat counters, combinational
// ----------------------------------------------------------------------------
module bea_step (
    input  bea_pkg::poll_state_t   cur_state,
    input  bea_pkg::in_item_t      item,
    input  bea_pkg::period_array_t periods,
    output bea_pkg::poll_state_t   nxt_state,
    output bea_pkg::out_item_t     result
);

    logic [bea_pkg::BYTE_W-1:0] now;
    logic [bea_pkg::BYTE_W-1:0] press;
    logic [bea_pkg::BYTE_W-1:0] release_bits;
    logic [bea_pkg::BYTE_W-1:0] fire;

    // held mask only follows a fresh read
    assign now = (item.sample_valid ? ~item.raw_buttons : cur_state.held)
               & bea_pkg::BUTTON_MASK;
    assign press        = now & ~cur_state.held;
    assign release_bits = cur_state.held & ~now;

    always_comb begin
        fire              = '0;
        nxt_state.held    = now;
        nxt_state.counter = cur_state.counter;
        for (int i = 0; i < bea_pkg::BUTTON_COUNT; i++) begin
            if (press[i] || (now[i] && (cur_state.counter[i] == '0))) begin
                nxt_state.counter[i] = periods[i];
                fire[i]              = 1'b1;
            end else if (now[i]) begin
                nxt_state.counter[i] = cur_state.counter[i] - bea_pkg::PERIOD_W'(1);
            end
        end
    end

    assign result.held_mask     = now;
    assign result.press_edges   = press;
    assign result.release_edges = release_bits;
    assign result.repeat_mask   = fire & bea_pkg::BUTTON_MASK;

endmodule

/* sv/button_edge_autorepeat_unit.sv */
// ----------------------------------------------------------------------------
// button_edge_autorepeat_unit
// Button edge detector with per-button auto-repeat, one result item per poll
// ----------------------------------------------------------------------------
// path: item accept into the input register, then one pass of per-button logic
//   into the result register
// throughput: 1 item per cycle while the result side is not stalled by m_ready
// reset: aresetn synchronous active low; held mask and counters clear, all
//   periods return to 4, both pipeline stages empty
// ----------------------------------------------------------------------------
module button_edge_autorepeat_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // poll items in
    input  logic                             s_valid,
    output logic                             s_ready,
    input  bea_pkg::in_item_t                s_item,
    // result items out
    output logic                             m_valid,
    input  logic                             m_ready,
    output bea_pkg::out_item_t               m_item,
    // period register writes
    input  logic                             cfg_wr_en,
    input  logic [bea_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bea_pkg::PERIOD_W-1:0]     cfg_wdata
);

    // input stage
    logic                 in_valid_reg;
    logic                 in_valid_next;
    bea_pkg::in_item_t    in_item_reg;

    // result stage
    logic                 out_valid_reg;
    logic                 out_valid_next;
    bea_pkg::out_item_t   out_item_reg;

    // poll state (held mask, repeat counters)
    bea_pkg::poll_state_t state_reg;
    bea_pkg::poll_state_t state_next;

    bea_pkg::period_array_t periods;
    bea_pkg::out_item_t     step_result;

    logic advance;   // input stage item moves into the result register
    logic in_take;   // new item accepted this cycle

    bea_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .periods   (periods)
    );

    bea_step u_step (
        .cur_state (state_reg),
        .item      (in_item_reg),
        .periods   (periods),
        .nxt_state (state_next),
        .result    (step_result)
    );

    // the result register parts the two sides: an item moves on whenever the
    // result slot is empty or being drained this cycle
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control and poll state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            // state only steps when its item is committed to the result
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

/* sv/bea_checker.sv */
// ----------------------------------------------------------------------------
// bea_checker
// Port-level checks on result items of the button edge detector
// ----------------------------------------------------------------------------
module bea_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input bea_pkg::out_item_t m_item
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))
        else $error("result item changed while stalled");

    // a press edge is on a button that is held now
    a_press_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_item.press_edges & ~m_item.held_mask) == '0))
        else $error("press edge on a button not held");

    // a release edge is on a button that is not held now
    a_release_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_item.release_edges & m_item.held_mask) == '0))
        else $error("release edge on a held button");

    // every press fires a repeat
    a_press_fires: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_item.press_edges & ~m_item.repeat_mask) == '0))
        else $error("press without repeat");

    // only held buttons repeat
    a_repeat_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_item.repeat_mask & ~m_item.held_mask) == '0))
        else $error("repeat on a button not held");

endmodule

bind button_edge_autorepeat_unit bea_checker u_bea_checker (.*);
